// ===== src/htfd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and the CRC-8 step for the sensor frame decoder.
// No dependencies; all other files but the two channel interfaces import it.
package htfd_pkg;

   localparam int CODE_W = 20;
   localparam int FRAC_W = 20;

   localparam logic [7:0] CRC_POLY = 8'h31;
   localparam logic [7:0] CRC_INIT = 8'hFF;

   // Byte positions within the seven-byte read frame
   localparam logic [2:0] POS_STATUS = 3'd0;
   localparam logic [2:0] POS_HUM_HI = 3'd1;
   localparam logic [2:0] POS_HUM_MID = 3'd2;
   localparam logic [2:0] POS_SPLIT = 3'd3;
   localparam logic [2:0] POS_TEMP_MID = 3'd4;
   localparam logic [2:0] POS_TEMP_LO = 3'd5;
   localparam logic [2:0] POS_CRC = 3'd6;

   localparam logic [13:0] HUM_SCALE = 14'd10000;
   localparam logic [14:0] TEMP_SCALE = 15'd20000;
   localparam logic [15:0] TEMP_OFFSET = 16'd5000;

   typedef struct packed {
      logic              crc_ok;
      logic [CODE_W-1:0] humidity_code;
      logic [CODE_W-1:0] temperature_code;
   } frame_result_type;

   // MSB-first CRC-8 over one byte, no final xor
   function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int k = 0; k < 8; k++) begin
         c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

endpackage

// ===== src/htfd_req_if.sv =====
`timescale 1ns / 1ps
// Request channel of the frame decoder: one frame byte per transfer.
// Standalone; no package needed.
interface htfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       frame_start;

   modport source (output valid, output data_byte, output frame_start, input ready);
   modport sink (input valid, input data_byte, input frame_start, output ready);
endinterface

// ===== src/htfd_rsp_if.sv =====
`timescale 1ns / 1ps
// Response channel of the frame decoder: one decoded frame per transfer.
// Standalone; no package needed.
interface htfd_rsp_if;
   logic               valid;
   logic               ready;
   logic               crc_ok;
   logic [13:0]        humidity_centi;
   logic signed [14:0] temperature_centi;
   logic [19:0]        humidity_raw;
   logic [19:0]        temperature_raw;

   modport source (output valid, output crc_ok, output humidity_centi,
                   output temperature_centi, output humidity_raw,
                   output temperature_raw, input ready);
   modport sink (input valid, input crc_ok, input humidity_centi,
                 input temperature_centi, input humidity_raw,
                 input temperature_raw, output ready);
endinterface

// ===== src/htfd_frame.sv =====
`timescale 1ns / 1ps
// Frame tracker: byte position, running CRC, raw code collection and the
// registered end-of-frame record. Depends on htfd_pkg.
module htfd_frame import htfd_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [7:0]       data_byte,
   input  logic             frame_start,
   output logic             frm_valid,
   input  logic             frm_ready,
   output frame_result_type frm_data
);

   logic [2:0]        pos_ff, pos_in;
   logic [7:0]        crc_ff, crc_in;
   logic [CODE_W-1:0] hum_ff, hum_in;
   logic [CODE_W-1:0] tmp_ff, tmp_in;
   logic              frm_valid_ff, frm_valid_in;
   frame_result_type  frm_data_ff, frm_data_in;

   logic       accept;
   logic [2:0] pos_cur;
   logic [7:0] crc_cur;
   logic       frm_load;

   assign in_ready = !frm_valid_ff || frm_ready;
   assign accept = in_valid && in_ready;
   assign pos_cur = frame_start ? POS_STATUS : pos_ff;
   assign crc_cur = frame_start ? CRC_INIT : crc_ff;
   assign frm_load = accept && (pos_cur == POS_CRC);

   always_comb begin
      pos_in = pos_ff;
      crc_in = crc_ff;
      hum_in = hum_ff;
      tmp_in = tmp_ff;
      if (accept) begin
         priority if (pos_cur < POS_CRC) begin
            crc_in = crc8_update(crc_cur, data_byte);
            pos_in = pos_cur + 3'd1;
            unique case (pos_cur)
               POS_HUM_HI:   hum_in[19:12] = data_byte;
               POS_HUM_MID:  hum_in[11:4] = data_byte;
               POS_SPLIT: begin
                  hum_in[3:0] = data_byte[7:4];
                  tmp_in[19:16] = data_byte[3:0];
               end
               POS_TEMP_MID: tmp_in[15:8] = data_byte;
               POS_TEMP_LO:  tmp_in[7:0] = data_byte;
               default: ;
            endcase
         end else begin
            // CRC byte closes the frame; the unused position just restarts
            pos_in = POS_STATUS;
            crc_in = CRC_INIT;
         end
      end
   end

   always_comb begin
      frm_data_in = frm_data_ff;
      if (frm_load) begin
         frm_data_in.crc_ok = (data_byte == crc_cur);
         frm_data_in.humidity_code = hum_ff;
         frm_data_in.temperature_code = tmp_ff;
      end
      priority if (frm_load) begin
         frm_valid_in = 1'b1;
      end else if (frm_ready) begin
         frm_valid_in = 1'b0;
      end else begin
         frm_valid_in = frm_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= POS_STATUS;
         crc_ff <= CRC_INIT;
         hum_ff <= '0;
         tmp_ff <= '0;
         frm_valid_ff <= 1'b0;
      end else begin
         pos_ff <= pos_in;
         crc_ff <= crc_in;
         hum_ff <= hum_in;
         tmp_ff <= tmp_in;
         frm_valid_ff <= frm_valid_in;
      end
      frm_data_ff <= frm_data_in;
   end

   assign frm_valid = frm_valid_ff;
   assign frm_data = frm_data_ff;

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_CRC)
      else $error("frame position left the seven-byte range");

   a_crc_restart: assert property (@(posedge clock) disable iff (reset)
      frm_load |=> (crc_ff == CRC_INIT) && (pos_ff == POS_STATUS))
      else $error("CRC or position not restarted after CRC byte");

   a_frm_hold: assert property (@(posedge clock) disable iff (reset)
      frm_valid_ff && !frm_ready |=> frm_valid_ff && $stable(frm_data_ff))
      else $error("stalled frame record changed");

endmodule

// ===== src/htfd_convert.sv =====
`timescale 1ns / 1ps
// Scaling stage: raw codes to hundredths, gated by the CRC result, into the
// response register. Depends on htfd_pkg.
module htfd_convert import htfd_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               frm_valid,
   output logic               frm_ready,
   input  frame_result_type   frm_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               crc_ok,
   output logic [13:0]        humidity_centi,
   output logic signed [14:0] temperature_centi,
   output logic [19:0]        humidity_raw,
   output logic [19:0]        temperature_raw
);

   logic [33:0] hum_prod;
   logic [34:0] tmp_prod;
   logic [15:0] tmp_diff;
   logic        load;

   logic        valid_ff, valid_in;
   logic        crc_ok_ff, crc_ok_in;
   logic [13:0] hum_ff, hum_in;
   logic [14:0] tmp_ff, tmp_in;
   logic [19:0] hraw_ff, hraw_in;
   logic [19:0] traw_ff, traw_in;

   assign frm_ready = !valid_ff || rsp_ready;
   assign load = frm_valid && frm_ready;

   always_comb begin
      hum_prod = {14'd0, frm_data.humidity_code} * {20'd0, HUM_SCALE};
      tmp_prod = {15'd0, frm_data.temperature_code} * {20'd0, TEMP_SCALE};
      tmp_diff = {1'b0, tmp_prod[34:FRAC_W]} - TEMP_OFFSET;

      crc_ok_in = crc_ok_ff;
      hum_in = hum_ff;
      tmp_in = tmp_ff;
      hraw_in = hraw_ff;
      traw_in = traw_ff;
      if (load) begin
         crc_ok_in = frm_data.crc_ok;
         // zero the scaled values on a bad CRC, keep raw codes
         hum_in = frm_data.crc_ok ? hum_prod[33:FRAC_W] : 14'd0;
         tmp_in = frm_data.crc_ok ? tmp_diff[14:0] : 15'd0;
         hraw_in = frm_data.humidity_code;
         traw_in = frm_data.temperature_code;
      end

      priority if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      crc_ok_ff <= crc_ok_in;
      hum_ff <= hum_in;
      tmp_ff <= tmp_in;
      hraw_ff <= hraw_in;
      traw_ff <= traw_in;
   end

   assign rsp_valid = valid_ff;
   assign crc_ok = crc_ok_ff;
   assign humidity_centi = hum_ff;
   assign temperature_centi = $signed(tmp_ff);
   assign humidity_raw = hraw_ff;
   assign temperature_raw = traw_ff;

   a_bad_crc_zero: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !crc_ok_ff |-> (hum_ff == 14'd0) && (tmp_ff == 15'd0))
      else $error("scaled values not zeroed on CRC failure");

   a_hum_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> hum_ff < HUM_SCALE)
      else $error("humidity above full scale");

endmodule

// ===== src/humidity_temp_frame_decoder.sv =====
`timescale 1ns / 1ps
// Decoder for the seven-byte humidity/temperature sensor read frame. It takes
// one byte per cycle while ready is high (status, five data bytes, CRC byte;
// frame_start realigns to the status byte) and returns one registered response
// per frame: CRC-8 check result (poly 0x31, init 0xFF), raw 20-bit codes,
// and humidity and temperature in hundredths, zero when the CRC fails. The
// CRC step on the incoming byte and the two scaling multipliers each
// sit between two registers, so none limits the byte rate; a stalled response
// still leaves room for one more finished frame before req ready drops.
// Depends on htfd_pkg, htfd_req_if, htfd_rsp_if, htfd_frame, htfd_convert.
module humidity_temp_frame_decoder import htfd_pkg::*; (
   input logic         clock,
   input logic         reset,
   htfd_req_if.sink    req_ch,
   htfd_rsp_if.source  rsp_ch
);

   logic             frm_valid;
   logic             frm_ready;
   frame_result_type frm_data;

   htfd_frame u_frame (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_ch.valid),
      .in_ready    (req_ch.ready),
      .data_byte   (req_ch.data_byte),
      .frame_start (req_ch.frame_start),
      .frm_valid   (frm_valid),
      .frm_ready   (frm_ready),
      .frm_data    (frm_data)
   );

   htfd_convert u_convert (
      .clock             (clock),
      .reset             (reset),
      .frm_valid         (frm_valid),
      .frm_ready         (frm_ready),
      .frm_data          (frm_data),
      .rsp_valid         (rsp_ch.valid),
      .rsp_ready         (rsp_ch.ready),
      .crc_ok            (rsp_ch.crc_ok),
      .humidity_centi    (rsp_ch.humidity_centi),
      .temperature_centi (rsp_ch.temperature_centi),
      .humidity_raw      (rsp_ch.humidity_raw),
      .temperature_raw   (rsp_ch.temperature_raw)
   );

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for humidity_temp_frame_decoder: a scoreboard class
// predicts every decoded frame; tasks drive requests, a process drives ready.
// Depends on htfd_pkg, htfd_req_if, htfd_rsp_if and the decoder RTL.
package htfd_tb_pkg;
   import htfd_pkg::*;

   localparam logic [39:0] HUM_SPAN_CENTI = 40'd10000;
   localparam logic [39:0] TEMP_SPAN_CENTI = 40'd20000;
   localparam logic [14:0] TEMP_OFFSET_CENTI = 15'd5000;

   typedef enum logic [1:0] {RX_STREAM, RX_CHOPPY, RX_SPARSE} rx_mode_type;

   typedef struct packed {
      logic               crc_ok;
      logic [13:0]        humidity_centi;
      logic signed [14:0] temperature_centi;
      logic [19:0]        humidity_raw;
      logic [19:0]        temperature_raw;
   } decoded_frame_type;

   function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] r;
      r = crc ^ b;
      repeat (8) r = r[7] ? ({r[6:0], 1'b0} ^ CRC_POLY) : {r[6:0], 1'b0};
      return r;
   endfunction

   class frame_scoreboard;
      logic [2:0]        byte_pos = POS_STATUS;
      logic [7:0]        crc_acc = CRC_INIT;
      logic [19:0]       hum_code = '0;
      logic [19:0]       temp_code = '0;
      decoded_frame_type pending_frames[$];
      int                frames_checked = 0;
      int                crc_pass_frames = 0;
      int                crc_fail_frames = 0;
      int                mismatches = 0;

      function int pending_count();
         return pending_frames.size();
      endfunction

      task report_mismatch(input string msg);
         mismatches++;
         $display("[%0t] MISMATCH %s", $time, msg);
      endtask

      // Advance the frame state by one accepted request byte.
      function void take_byte(input logic [7:0] b, input logic start);
         decoded_frame_type f;
         logic [39:0]       scaled;
         logic [2:0]        p;
         if (start) begin
            byte_pos = POS_STATUS;
            crc_acc = CRC_INIT;
         end
         p = byte_pos;
         if (p < POS_CRC) begin
            crc_acc = crc8_next(crc_acc, b);
            case (p)
               POS_HUM_HI: hum_code[19:12] = b;
               POS_HUM_MID: hum_code[11:4] = b;
               POS_SPLIT: begin
                  hum_code[3:0] = b[7:4];
                  temp_code[19:16] = b[3:0];
               end
               POS_TEMP_MID: temp_code[15:8] = b;
               POS_TEMP_LO: temp_code[7:0] = b;
               default: ;
            endcase
            byte_pos = p + 3'd1;
         end else begin
            if (p == POS_CRC) begin
               f.crc_ok = (b == crc_acc);
               f.humidity_raw = hum_code;
               f.temperature_raw = temp_code;
               f.humidity_centi = '0;
               f.temperature_centi = '0;
               if (f.crc_ok) begin
                  scaled = ({20'd0, hum_code} * HUM_SPAN_CENTI) >> FRAC_W;
                  f.humidity_centi = scaled[13:0];
                  scaled = ({20'd0, temp_code} * TEMP_SPAN_CENTI) >> FRAC_W;
                  f.temperature_centi = scaled[14:0] - TEMP_OFFSET_CENTI;
               end
               pending_frames.push_back(f);
            end
            byte_pos = POS_STATUS;
            crc_acc = CRC_INIT;
         end
      endfunction

      task check_frame(input decoded_frame_type got);
         decoded_frame_type want;
         if (pending_frames.size() == 0) begin
            report_mismatch($sformatf("response with nothing pending: crc_ok=%0b hum_raw=%05h",
                                      got.crc_ok, got.humidity_raw));
            return;
         end
         want = pending_frames.pop_front();
         frames_checked++;
         if (want.crc_ok) crc_pass_frames++;
         else crc_fail_frames++;
         if (got.crc_ok !== want.crc_ok)
            report_mismatch($sformatf("frame %0d crc_ok got %0b want %0b",
                                      frames_checked, got.crc_ok, want.crc_ok));
         if (got.humidity_centi !== want.humidity_centi)
            report_mismatch($sformatf("frame %0d humidity_centi got %0d want %0d",
                                      frames_checked, got.humidity_centi, want.humidity_centi));
         if (got.temperature_centi !== want.temperature_centi)
            report_mismatch($sformatf("frame %0d temperature_centi got %0d want %0d",
                                      frames_checked, got.temperature_centi,
                                      want.temperature_centi));
         if (got.humidity_raw !== want.humidity_raw)
            report_mismatch($sformatf("frame %0d humidity_raw got %05h want %05h",
                                      frames_checked, got.humidity_raw, want.humidity_raw));
         if (got.temperature_raw !== want.temperature_raw)
            report_mismatch($sformatf("frame %0d temperature_raw got %05h want %05h",
                                      frames_checked, got.temperature_raw,
                                      want.temperature_raw));
      endtask
   endclass
endpackage

module tb_top;
   import htfd_pkg::*;
   import htfd_tb_pkg::*;

   localparam int RANDOM_REQUESTS = 600;
   localparam int LONG_STALL_CYCLES = 400;
   localparam int DRAIN_CYCLES = 20;

   logic clock;
   logic reset;

   htfd_req_if req_if();
   htfd_rsp_if rsp_if();

   humidity_temp_frame_decoder dut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_if),
      .rsp_ch(rsp_if)
   );

   frame_scoreboard sb;
   int              requests_sent = 0;
   int              burst_left = 0;
   bit              long_stall_req = 0;
   int              long_stalls_done = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("Timeout with %0d responses still pending", sb.pending_count());
      $display("Simulation FAILED");
      $finish;
   end

   // Offer one request and hold it until taken; then maybe end the burst.
   task automatic offer(input logic [7:0] b, input logic start);
      int gap;
      req_if.valid <= 1'b1;
      req_if.data_byte <= b;
      req_if.frame_start <= start;
      do @(posedge clock); while (!req_if.ready);
      sb.take_byte(b, start);
      requests_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = $urandom_range(1, 8);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80) : $urandom_range(0, 12);
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_frame(input logic [7:0] status, input logic [19:0] hc,
                             input logic [19:0] tc, input bit crc_good, input logic start);
      logic [7:0] frame_bytes [7];
      logic [7:0] crc;
      frame_bytes[0] = status;
      frame_bytes[1] = hc[19:12];
      frame_bytes[2] = hc[11:4];
      frame_bytes[3] = {hc[3:0], tc[19:16]};
      frame_bytes[4] = tc[15:8];
      frame_bytes[5] = tc[7:0];
      crc = CRC_INIT;
      for (int i = 0; i < 6; i++) crc = crc8_next(crc, frame_bytes[i]);
      frame_bytes[6] = crc_good ? crc : crc ^ 8'($urandom_range(1, 255));
      offer(frame_bytes[0], start);
      for (int i = 1; i < 7; i++) offer(frame_bytes[i], 1'b0);
   endtask

   function automatic logic [19:0] pick_code();
      case ($urandom_range(0, 7))
         0: return 20'h00000;
         1: return 20'hFFFFF;
         default: return 20'($urandom);
      endcase
   endfunction

   // Response side: check each taken response, then pick the next ready value.
   initial begin
      rx_mode_type mode;
      int          mode_left;
      int          stall_left;
      mode = RX_STREAM;
      mode_left = 50;
      stall_left = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready)
            sb.check_frame({rsp_if.crc_ok, rsp_if.humidity_centi, rsp_if.temperature_centi,
                            rsp_if.humidity_raw, rsp_if.temperature_raw});
         if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else if (long_stall_req) begin
            long_stall_req = 0;
            long_stalls_done++;
            stall_left = LONG_STALL_CYCLES - 1;
            rsp_if.ready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode = rx_mode_type'($urandom_range(0, 2));
               mode_left = $urandom_range(16, 96);
            end else begin
               mode_left--;
            end
            case (mode)
               RX_STREAM: rsp_if.ready <= 1'b1;
               RX_CHOPPY: rsp_if.ready <= 1'($urandom_range(0, 1));
               default: rsp_if.ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   initial begin
      bit aligned;
      bit hold_done;
      bit pause_done;
      int n;
      sb = new;
      aligned = 0;
      hold_done = 0;
      pause_done = 0;
      reset <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.data_byte <= 8'h00;
      req_if.frame_start <= 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Lowest codes, then highest codes back to back without frame start
      send_frame(8'h18, 20'h00000, 20'h00000, 1'b1, 1'b1);
      send_frame(8'hFF, 20'hFFFFF, 20'hFFFFF, 1'b1, 1'b0);
      // Truncated frame, then realign onto a frame with a bad CRC byte
      offer(8'h1C, 1'b1);
      offer(8'h80, 1'b0);
      offer(8'h00, 1'b0);
      send_frame(8'h00, 20'($urandom), 20'($urandom), 1'b0, 1'b1);

      while (requests_sent < RANDOM_REQUESTS + 24) begin
         if (!hold_done && requests_sent >= 150) begin
            long_stall_req = 1;
            hold_done = 1;
         end
         if (!pause_done && requests_sent >= 400) begin
            pause_done = 1;
            req_if.valid <= 1'b0;
            do @(posedge clock); while (sb.pending_count() != 0);
         end
         if ($urandom_range(0, 99) < 12) begin
            // Noise: partial frames with stray frame starts
            n = $urandom_range(1, 6);
            repeat (n) offer(8'($urandom), ($urandom_range(0, 3) == 0));
            aligned = 0;
         end else begin
            send_frame(8'($urandom), pick_code(), pick_code(), ($urandom_range(0, 3) != 0),
                       aligned ? 1'($urandom_range(0, 1)) : 1'b1);
            aligned = 1;
         end
      end
      req_if.valid <= 1'b0;

      while (sb.pending_count() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d request bytes; checked %0d frames (%0d CRC pass, %0d CRC fail).",
               requests_sent, sb.frames_checked, sb.crc_pass_frames, sb.crc_fail_frames);
      $display("Included %0d long response hold-off(s), one full drain, and %0d mismatch(es).",
               long_stalls_done, sb.mismatches);
      if (sb.mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule
